// ===== rtl/core/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// shared constants and controller/datapath interface types for the
// most frequent byte finder
// ----------------------------------------------------------------------------
`default_nettype none

package mfb_pkg;

   // count store geometry
   localparam int unsigned SymW    = 8;
   localparam int unsigned CountW  = 8;

   // saturation limit of one histogram entry
   localparam logic [CountW-1:0] MaxLen = 8'd255;

   // byte code that ends a string
   localparam logic [SymW-1:0] SymEnd = 8'd0;

   // commands from the controller to the datapath
   typedef struct packed {
      logic take;    // input transfer accepted this cycle
      logic clear;   // write zero at the sweep index, advance it
      logic init;    // reset best code and count ahead of a scan
      logic scan;    // read the entry at the sweep index, advance it
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic idx_last;   // sweep index sits on the final entry
   } status_type;

endpackage : mfb_pkg

`default_nettype wire

// ===== rtl/core/mfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfb_ctrl
// controller: clearing sweep after reset, byte intake, scan sequencing
// and the result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [mfb_pkg::SymW-1:0] req_symbol,
   input  wire mfb_pkg::status_type    status,
   output mfb_pkg::cmd_type            cmd,
   output logic                        busy,
   output logic                        rsp_valid
);
   import mfb_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_DRAIN  = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_FINISH = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      take;

   // an input transfer happens only while idle
   assign take = start && (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.idx_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take && (req_symbol == SymEnd)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.idx_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands and port status
   always_comb begin
      cmd.take  = take;
      cmd.clear = (state_ff == ST_CLEAR);
      cmd.init  = (state_ff == ST_DRAIN);
      cmd.scan  = (state_ff == ST_SCAN);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule : mfb_ctrl

`default_nettype wire

// ===== rtl/core/mfb_datapath.sv =====
// ----------------------------------------------------------------------------
// mfb_datapath
// count store with one write and one registered read port, saturating
// increment with forwarding, and the running best of the scan
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [mfb_pkg::SymW-1:0]   req_symbol,
   input  wire mfb_pkg::cmd_type           cmd,
   output mfb_pkg::status_type             status,
   output logic [mfb_pkg::SymW-1:0]        rsp_top_symbol,
   output logic [mfb_pkg::CountW-1:0]      rsp_top_count,
   output logic                            rsp_found
);
   import mfb_pkg::*;

   localparam int unsigned Depth = 2 ** SymW;

   logic [CountW-1:0] mem [Depth];

   logic [SymW-1:0]   idx_ff, idx_in;
   logic              byte_vld_ff;
   logic [SymW-1:0]   byte_addr_ff;
   logic              scan_vld_ff;
   logic [SymW-1:0]   scan_addr_ff;
   logic              fwd_vld_ff;
   logic [SymW-1:0]   fwd_addr_ff;
   logic [CountW-1:0] fwd_data_ff;
   logic [CountW-1:0] rd_data_ff;
   logic [SymW-1:0]   best_sym_ff;
   logic [CountW-1:0] best_cnt_ff;

   logic [SymW-1:0]   rd_addr;
   logic [CountW-1:0] cur_cnt;
   logic [CountW-1:0] inc_cnt;
   logic              wr_en;
   logic [SymW-1:0]   wr_addr;
   logic [CountW-1:0] wr_data;

   // sweep index shared by the clearing pass and the scan
   always_comb begin
      idx_in = idx_ff;
      if (cmd.clear || cmd.scan) idx_in = idx_ff + 1'b1;
   end

   assign status.idx_last = (idx_ff == SymW'(Depth - 1));

   // read address: sweep index while scanning, else the incoming byte
   assign rd_addr = cmd.scan ? idx_ff : req_symbol;

   // forward the previous write when it hits the same entry
   assign cur_cnt = (fwd_vld_ff && (fwd_addr_ff == byte_addr_ff)) ? fwd_data_ff
                                                                  : rd_data_ff;
   assign inc_cnt = (cur_cnt < MaxLen) ? cur_cnt + 1'b1 : cur_cnt;

   // single write port: clearing sweep, scan clear-behind, byte update
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = byte_addr_ff;
      wr_data = inc_cnt;
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = '0;
      end else if (scan_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = scan_addr_ff;
         wr_data = '0;
      end else if (byte_vld_ff) begin
         wr_en   = 1'b1;
      end
   end

   // count store
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         byte_vld_ff <= 1'b0;
         scan_vld_ff <= 1'b0;
         fwd_vld_ff  <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         byte_vld_ff <= cmd.take && (req_symbol != SymEnd);
         scan_vld_ff <= cmd.scan;
         fwd_vld_ff  <= byte_vld_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_addr_ff <= req_symbol;
      scan_addr_ff <= idx_ff;
      fwd_addr_ff  <= byte_addr_ff;
      fwd_data_ff  <= inc_cnt;
   end

   // running best: strictly larger wins, so ties keep the lower code
   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         best_sym_ff <= '0;
         best_cnt_ff <= '0;
      end else if (scan_vld_ff && (rd_data_ff > best_cnt_ff)) begin
         best_sym_ff <= scan_addr_ff;
         best_cnt_ff <= rd_data_ff;
      end
   end

   assign rsp_top_symbol = best_sym_ff;
   assign rsp_top_count  = best_cnt_ff;
   assign rsp_found      = (best_cnt_ff != '0);

endmodule : mfb_datapath

`default_nettype wire

// ===== rtl/core/most_frequent_byte_finder.sv =====
// ----------------------------------------------------------------------------
// most_frequent_byte_finder
// byte histogram mode: counts the bytes of a zero-terminated string and
// reports the most frequent code, lowest code on ties
// ----------------------------------------------------------------------------
//  channel   ports                                             transfer
//  request   start, busy, req_symbol                           start & !busy
//  response  rsp_valid, rsp_top_symbol, rsp_top_count,         rsp_valid
//            rsp_found
//
//  a nonzero byte leaves busy low; a read-modify-write on the count store
//  with forwarding lets bytes follow back to back
//  the terminating zero holds busy through a drain state, a 256-entry
//  scan through the single read port, a compare state and the one-cycle
//  result strobe
//  after reset a clearing pass over all 256 entries zeroes the store, busy high
//  results are shown for one cycle only; the receiver cannot stall them
// ----------------------------------------------------------------------------
`default_nettype none

module most_frequent_byte_finder (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [mfb_pkg::SymW-1:0]   req_symbol,
   output logic                            rsp_valid,
   output logic [mfb_pkg::SymW-1:0]        rsp_top_symbol,
   output logic [mfb_pkg::CountW-1:0]      rsp_top_count,
   output logic                            rsp_found
);
   import mfb_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing
   mfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_symbol (req_symbol),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   // count store and scan
   mfb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_symbol     (req_symbol),
      .cmd            (cmd),
      .status         (status),
      .rsp_top_symbol (rsp_top_symbol),
      .rsp_top_count  (rsp_top_count),
      .rsp_found      (rsp_found)
   );

endmodule : most_frequent_byte_finder

`default_nettype wire

// ===== rtl/core/mfb_checker.sv =====
// ----------------------------------------------------------------------------
// mfb_checker
// port-level checks on the most frequent byte finder
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [7:0] req_symbol,
   input wire logic       rsp_valid,
   input wire logic [7:0] rsp_top_count,
   input wire logic       rsp_found
);
   import mfb_pkg::*;

   // a result strobe lasts exactly one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // results appear only while the block is occupied
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // the block is free again right after a result
   a_free_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("still busy after result transfer");

   // a terminating zero occupies the block
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_symbol == SymEnd)) |=> busy)
      else $error("terminator transfer did not start a scan");

   // found flag agrees with the reported count
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_top_count != 8'd0)))
      else $error("found flag disagrees with count");

endmodule : mfb_checker

bind most_frequent_byte_finder mfb_checker u_mfb_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_symbol    (req_symbol),
   .rsp_valid     (rsp_valid),
   .rsp_top_count (rsp_top_count),
   .rsp_found     (rsp_found)
);

`default_nettype wire

// ===== tb/most_frequent_byte_finder_test.sv =====
// ----------------------------------------------------------------------------
// most_frequent_byte_finder_test
// self-checking bench for the byte histogram mode finder: a table of
// directed strings, two codes driven past saturation, then random
// zero-terminated strings with random gaps; each result strobe is checked
// against a local histogram predictor, or a typed table row's own expectation
`default_nettype none

module most_frequent_byte_finder_test;

   timeunit 1ns;
   timeprecision 1ps;

   import mfb_pkg::*;

   // one result transfer
   typedef struct packed {
      logic [SymW-1:0]   top_symbol;
      logic [CountW-1:0] top_count;
      logic              found;
   } mode_result_type;

   // one row of the directed table; typed rows carry their own expectation
   typedef struct packed {
      logic [SymW-1:0] symbol;
      logic            typed;
      mode_result_type want;
   } string_row_type;

   localparam int DirRows      = 25;
   localparam int RandomItems  = 1525;
   localparam int CycleLimit   = 5000000;
   localparam int DrainCycles  = 300;

   localparam string_row_type DirectedRows [DirRows] = '{
      // empty string straight after reset
      '{SymEnd, 1'b1, '{8'd0, 8'd0, 1'b0}},
      // top code
      '{8'd255, 1'b0, '0},
      '{SymEnd, 1'b1, '{8'd255, 8'd1, 1'b1}},
      // lowest nonzero code
      '{8'd1, 1'b0, '0},
      '{SymEnd, 1'b1, '{8'd1, 8'd1, 1'b1}},
      // codes either side of the sign boundary
      '{8'd128, 1'b0, '0},
      '{8'd127, 1'b0, '0},
      '{8'd128, 1'b0, '0},
      '{SymEnd, 1'b1, '{8'd128, 8'd2, 1'b1}},
      // tie, lower code wins
      '{8'd9, 1'b0, '0},
      '{8'd3, 1'b0, '0},
      '{8'd3, 1'b0, '0},
      '{8'd9, 1'b0, '0},
      '{SymEnd, 1'b0, '0},
      // empty again, store must have been cleared by the scan
      '{SymEnd, 1'b1, '{8'd0, 8'd0, 1'b0}},
      // alternating bit patterns
      '{8'd85, 1'b0, '0},
      '{8'd170, 1'b0, '0},
      '{SymEnd, 1'b0, '0},
      // three counts each, high code ties with low code
      '{8'd200, 1'b0, '0},
      '{8'd7, 1'b0, '0},
      '{8'd200, 1'b0, '0},
      '{8'd7, 1'b0, '0},
      '{8'd200, 1'b0, '0},
      '{8'd7, 1'b0, '0},
      '{SymEnd, 1'b0, '0}
   };

   logic            clock = 1'b0;
   logic            reset;
   logic            start;
   logic            busy;
   logic [SymW-1:0] req_symbol;
   logic            rsp_valid;
   logic [SymW-1:0] rsp_top_symbol;
   logic [CountW-1:0] rsp_top_count;
   logic            rsp_found;

   // predictor state and the queue of expected results
   logic [CountW-1:0] byte_tally [256];
   mode_result_type   pending_modes [$];
   logic [SymW-1:0]   string_bytes [$];

   int fail_count   = 0;
   int items_sent   = 0;
   int cycle_count  = 0;
   int no_idle_left = 0;

   most_frequent_byte_finder u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_symbol     (req_symbol),
      .rsp_valid      (rsp_valid),
      .rsp_top_symbol (rsp_top_symbol),
      .rsp_top_count  (rsp_top_count),
      .rsp_found      (rsp_found)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("most_frequent_byte_finder verification failed");
         $finish;
      end
   end

   // scan the tally, lowest code kept on ties, clearing as it goes
   function automatic mode_result_type close_string();
      mode_result_type best;
      best = '0;
      for (int code = 0; code < 256; code++) begin
         if (byte_tally[SymW'(code)] > best.top_count) begin
            best.top_count  = byte_tally[SymW'(code)];
            best.top_symbol = code[SymW-1:0];
         end
         byte_tally[SymW'(code)] = '0;
      end
      best.found = (best.top_count != '0);
      return best;
   endfunction

   // idle length ahead of a transfer: mostly short, a few long, some bursts
   function automatic int pick_gap();
      int roll;
      if (no_idle_left > 0) begin
         no_idle_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         no_idle_left = $urandom_range(10, 60);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // one input transfer, then the predictor update
   task automatic send_symbol(input logic [SymW-1:0] sym, input logic typed,
                              input mode_result_type want);
      int gap;
      mode_result_type got;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_symbol <= sym;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (sym != SymEnd) begin
         if (byte_tally[sym] < MaxLen) byte_tally[sym] = byte_tally[sym] + 1'b1;
      end else begin
         got = close_string();
         pending_modes.push_back(typed ? want : got);
      end
   endtask

   // send the queued string bytes
   task automatic send_string_bytes();
      while (string_bytes.size() > 0) send_symbol(string_bytes.pop_front(), 1'b0, '0);
   endtask

   // result checker
   always @(posedge clock) begin
      mode_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_modes.size() == 0) begin
            $error("unexpected result transfer: top_symbol %0d top_count %0d found %0d",
                   rsp_top_symbol, rsp_top_count, rsp_found);
            fail_count++;
         end else begin
            want = pending_modes.pop_front();
            if (rsp_top_symbol !== want.top_symbol) begin
               $error("top_symbol: expected %0d, actual %0d", want.top_symbol, rsp_top_symbol);
               fail_count++;
            end
            if (rsp_top_count !== want.top_count) begin
               $error("top_count: expected %0d, actual %0d", want.top_count, rsp_top_count);
               fail_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_found);
               fail_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [SymW-1:0] code_a;
      logic [SymW-1:0] code_b;
      int left_a;
      int left_b;
      int roll;
      int len;
      logic [SymW-1:0] pool [3];

      for (int code = 0; code < 256; code++) byte_tally[SymW'(code)] = '0;
      reset      = 1'b1;
      start      = 1'b0;
      req_symbol = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int row = 0; row < DirRows; row++)
         send_symbol(DirectedRows[5'(row)].symbol, DirectedRows[5'(row)].typed,
                     DirectedRows[5'(row)].want);

      // two codes driven past saturation, interleaved with a little noise
      code_a = SymW'($urandom_range(1, 255));
      do code_b = SymW'($urandom_range(1, 255)); while (code_b == code_a);
      left_a = 256 + $urandom_range(0, 5);
      left_b = 256 + $urandom_range(0, 5);
      while (left_a + left_b > 0) begin
         roll = $urandom_range(0, 99);
         if (roll < 2) string_bytes.push_back(SymW'($urandom_range(1, 255)));
         else if ((roll < 51 && left_a > 0) || left_b == 0) begin
            string_bytes.push_back(code_a);
            left_a--;
         end else begin
            string_bytes.push_back(code_b);
            left_b--;
         end
      end
      string_bytes.push_back(SymEnd);
      send_string_bytes();

      // random strings
      while (items_sent < DirRows + RandomItems) begin
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            // short string of random nonzero bytes
            len = $urandom_range(1, 12);
            repeat (len) string_bytes.push_back(SymW'($urandom_range(1, 255)));
            string_bytes.push_back(SymEnd);
         end else if (roll < 85) begin
            // few distinct codes, many repeats, plenty of ties
            for (int k = 0; k < 3; k++) pool[2'(k)] = SymW'($urandom_range(1, 255));
            len = $urandom_range(2, 30);
            repeat (len) string_bytes.push_back(pool[2'($urandom_range(0, 2))]);
            string_bytes.push_back(SymEnd);
         end else if (roll < 92) begin
            // empty string
            string_bytes.push_back(SymEnd);
         end else begin
            // raw noise, terminators anywhere
            len = $urandom_range(1, 20);
            repeat (len) string_bytes.push_back(SymW'($urandom_range(0, 255)));
         end
         send_string_bytes();
      end
      start <= 1'b0;

      // drain, then let any stray strobe show up
      while (pending_modes.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0 && pending_modes.size() == 0)
         $display("most_frequent_byte_finder verification clean");
      else
         $display("most_frequent_byte_finder verification failed");
      $finish;
   end

endmodule : most_frequent_byte_finder_test

`default_nettype wire
